// ===== rtl/core/tcc_pkg.sv =====
// Shared constants, width helpers and control types for the tetrahedron circumcenter block.
`timescale 1ns / 1ps
package tcc_pkg;

	// defaults for the top-level parameters
	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;

	// fixed field widths
	localparam int OUT_W  = 48;
	localparam int THR_W  = 32;

	// quotient bits kept by the divider; anything larger always clips
	localparam int QB     = OUT_W + 1;

	// depth of the queue between front and back
	localparam int QDEPTH = 4;

	// accept edge to strobe edge: 5 front stages, queue, 2 back stages,
	// divider (QB + 1), sum stage, output stage
	localparam int LATENCY = 11 + QB;

	// numerator determinant width (signed)
	function automatic int nw_f(input int c);
		return 4 * c + 6;
	endfunction

	// denominator determinant width (signed)
	function automatic int denw_f(input int c);
		return 3 * c + 4;
	endfunction

	// word passed from front to back: degenerate flag, p, three numerators, denominator
	function automatic int plw_f(input int c);
		return 1 + 3 * c + 3 * nw_f(c) + denw_f(c);
	endfunction

	// queue status seen by the top level
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== rtl/core/tcc_front.sv =====
// Front part: edge vectors, squared lengths, determinants and degenerate test.
`timescale 1ns / 1ps
module tcc_front import tcc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic [11:0][COORD_BITS-1:0]       crd,
	input  logic [THR_W-1:0]                  thr,
	output logic                              out_vld,
	output logic [plw_f(COORD_BITS)-1:0]      out_word
);

	localparam int C    = COORD_BITS;
	localparam int DW   = C + 1;
	localparam int MW   = 2 * C + 3;
	localparam int SQW  = 2 * C + 3;
	localparam int NW   = nw_f(C);
	localparam int DENW = denw_f(C);
	localparam int CW   = ((DENW > THR_W + 1) ? DENW : THR_W + 1) + 1;

	// first and second row (or column) of the 2x2 minor that leaves out index e
	function automatic int ia(input int e);
		return (e == 0) ? 1 : 0;
	endfunction

	function automatic int ib(input int e);
		return (e == 2) ? 1 : 2;
	endfunction

	// 2x2 minor a*b - c*d
	function automatic logic signed [MW-1:0] minor2(
		input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b,
		input logic signed [DW-1:0] c,
		input logic signed [DW-1:0] d
	);
		logic signed [2*DW-1:0] p1;
		logic signed [2*DW-1:0] p2;
		p1 = a * b;
		p2 = c * d;
		return MW'(p1) - MW'(p2);
	endfunction

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DW-1:0]   d_s1 [3][3];
	logic [2:0][C-1:0]      p_s1, p_s2, p_s3, p_s4, p_s5;
	logic signed [SQW-1:0]  sq_s2 [3];
	logic signed [MW-1:0]   mn_s2 [3][3];
	logic signed [DW-1:0]   dz_s2 [3];
	logic signed [NW-1:0]   pn_s3 [3][3];
	logic signed [DENW-1:0] pd_s3 [3];
	logic signed [NW-1:0]   num_s4 [3];
	logic signed [DENW-1:0] den_s4;
	logic signed [NW-1:0]   num_s5 [3];
	logic signed [DENW-1:0] den_s5;
	logic                   degen_s5;
	logic signed [CW-1:0]   den_e;
	logic signed [CW-1:0]   thr_e;

	// valid chain, stalls as a whole
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// s1: edge vectors from the first vertex
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					d_s1[r][c] <= DW'(signed'(crd[3*(r+1)+c])) - DW'(signed'(crd[c]));
				end
			end
			for (int c = 0; c < 3; c++) begin
				p_s1[c] <= crd[c];
			end
		end
	end

	// s2: squared lengths and all 2x2 minors of the edge matrix
	// mn[k][e]: columns without k, rows without e
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				sq_s2[r] <= SQW'(d_s1[r][0] * d_s1[r][0]) + SQW'(d_s1[r][1] * d_s1[r][1])
					+ SQW'(d_s1[r][2] * d_s1[r][2]);
				dz_s2[r] <= d_s1[r][2];
			end
			for (int k = 0; k < 3; k++) begin
				for (int e = 0; e < 3; e++) begin
					mn_s2[k][e] <= minor2(d_s1[ia(e)][ia(k)], d_s1[ib(e)][ib(k)],
						d_s1[ib(e)][ia(k)], d_s1[ia(e)][ib(k)]);
				end
			end
			p_s2 <= p_s1;
		end
	end

	// s3: cofactor products (expansion along the last column)
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int e = 0; e < 3; e++) begin
					pn_s3[k][e] <= sq_s2[e] * mn_s2[k][e];
				end
			end
			for (int e = 0; e < 3; e++) begin
				pd_s3[e] <= dz_s2[e] * mn_s2[2][e];
			end
			p_s3 <= p_s2;
		end
	end

	// s4: determinant sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s4[k] <= pn_s3[k][0] - pn_s3[k][1] + pn_s3[k][2];
			end
			den_s4 <= pd_s3[0] - pd_s3[1] + pd_s3[2];
			p_s4   <= p_s3;
		end
	end

	// s5: |den| <= thr as two signed compares
	assign den_e = CW'(den_s4);
	assign thr_e = signed'(CW'(thr));

	always_ff @(posedge clk) begin
		if (en) begin
			degen_s5 <= (den_e <= thr_e) && (den_e >= -thr_e);
			num_s5   <= num_s4;
			den_s5   <= den_s4;
			p_s5     <= p_s4;
		end
	end

	assign out_vld  = v_s5;
	assign out_word = {degen_s5, p_s5[0], p_s5[1], p_s5[2],
		num_s5[0], num_s5[1], num_s5[2], den_s5};

endmodule

// ===== rtl/core/tcc_fifo.sv =====
// Short word queue between the front and back parts.
`timescale 1ns / 1ps
module tcc_fifo import tcc_pkg::*; #(
	parameter int W     = 8,
	parameter int DEPTH = QDEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output q_stat_t      stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign dout       = mem_q[rd_q];
	assign stat.full  = (cnt_q == (AW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule

// ===== rtl/core/tcc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps
module tcc_div import tcc_pkg::*; #(
	parameter int HW   = 8,
	parameter int YW   = 8,
	parameter int NQ   = QB
) (
	input  logic          clk,
	input  logic [HW-1:0] hi,
	input  logic [NQ-1:0] lo,
	input  logic [YW-1:0] y,
	output logic [NQ-1:0] q,
	output logic          ovf
);

	localparam int CW = ((HW > YW) ? HW : YW);

	logic [YW-1:0] rem_q [NQ+1];
	logic [NQ-1:0] lo_q  [NQ+1];
	logic [NQ-1:0] qt_q  [NQ+1];
	logic [YW-1:0] y_q   [NQ+1];
	logic          ovf_q [NQ+1];
	logic [YW:0]   t_c   [NQ+1];
	logic          ge_c  [NQ+1];

	// trial subtract for each stage
	always_comb begin
		t_c[0]  = '0;
		ge_c[0] = 1'b0;
		for (int i = 1; i <= NQ; i++) begin
			t_c[i]  = {rem_q[i-1], lo_q[i-1][NQ-i]};
			ge_c[i] = (t_c[i] >= {1'b0, y_q[i-1]});
		end
	end

	// stage 0: quotient too large when the high part already reaches y
	always_ff @(posedge clk) begin
		ovf_q[0] <= (CW'(hi) >= CW'(y));
		rem_q[0] <= YW'(hi);
		lo_q[0]  <= lo;
		y_q[0]   <= y;
		qt_q[0]  <= '0;
		for (int i = 1; i <= NQ; i++) begin
			rem_q[i] <= ge_c[i] ? YW'(t_c[i] - {1'b0, y_q[i-1]}) : YW'(t_c[i]);
			qt_q[i]  <= {qt_q[i-1][NQ-2:0], ge_c[i]};
			lo_q[i]  <= lo_q[i-1];
			y_q[i]   <= y_q[i-1];
			ovf_q[i] <= ovf_q[i-1];
		end
	end

	assign q   = qt_q[NQ];
	assign ovf = ovf_q[NQ];

endmodule

// ===== rtl/core/tcc_back.sv =====
// Back part: magnitudes, three dividers, rounding offset, sign, clipping and result word.
`timescale 1ns / 1ps
module tcc_back import tcc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [plw_f(COORD_BITS)-1:0]  in_word,
	output logic                          done,
	output logic                          valid_res,
	output logic signed [OUT_W-1:0]       center_x,
	output logic signed [OUT_W-1:0]       center_y,
	output logic signed [OUT_W-1:0]       center_z,
	output logic                          saturated
);

	localparam int C    = COORD_BITS;
	localparam int F    = FRAC_BITS;
	localparam int NW   = nw_f(C);
	localparam int NMW  = NW - 1;
	localparam int DENW = denw_f(C);
	localparam int YW   = DENW;
	localparam int XW   = NMW + F + 1;
	localparam int XE   = (XW > QB) ? XW : QB + 1;
	localparam int HW   = XE - QB;
	localparam int TW   = ((C + F > QB + 1) ? C + F : QB + 1) + 1;
	localparam int SW   = 1 + 3 + 3 * C;

	localparam logic signed [TW-1:0] OMAX = {{(TW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [TW-1:0] OMIN = {{(TW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

	logic                   degen_w;
	logic [2:0][C-1:0]      p_w;
	logic signed [NW-1:0]   n_w [3];
	logic signed [DENW-1:0] den_w;

	assign {degen_w, p_w[0], p_w[1], p_w[2], n_w[0], n_w[1], n_w[2], den_w} = in_word;

	logic                   v_s1, v_s2, v_s3;
	logic [NMW-1:0]         nm_s1 [3];
	logic [DENW-2:0]        dm_s1;
	logic [2:0]             qneg_s1, qneg_s2;
	logic [2:0][C-1:0]      p_s1, p_s2;
	logic                   degen_s1, degen_s2;
	logic [XE-1:0]          x_s2 [3];
	logic [YW-1:0]          y_s2;
	logic                   sv_q [QB+1];
	logic [SW-1:0]          sd_q [QB+1];
	logic [QB-1:0]          q_w [3];
	logic                   ovf_w [3];
	logic                   degen_d;
	logic [2:0]             qneg_d;
	logic [2:0][C-1:0]      p_d;
	logic signed [TW-1:0]   tot_s3 [3];
	logic [2:0]             ovf_s3, qneg_s3;
	logic                   degen_s3;
	logic signed [OUT_W-1:0] c_c [3];
	logic [2:0]             sat_c;

	// valid chain through the whole back part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			done <= 1'b0;
			for (int i = 0; i <= QB; i++) begin
				sv_q[i] <= 1'b0;
			end
		end else begin
			v_s1    <= in_vld;
			v_s2    <= v_s1;
			sv_q[0] <= v_s2;
			for (int i = 1; i <= QB; i++) begin
				sv_q[i] <= sv_q[i-1];
			end
			v_s3 <= sv_q[QB];
			done <= v_s3;
		end
	end

	// s1: magnitudes and result sign (y takes the opposite sign)
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			nm_s1[k]   <= NMW'(n_w[k][NW-1] ? -n_w[k] : n_w[k]);
			qneg_s1[k] <= n_w[k][NW-1] ^ den_w[DENW-1] ^ (k == 1);
		end
		dm_s1    <= (DENW-1)'(den_w[DENW-1] ? -den_w : den_w);
		p_s1     <= p_w;
		degen_s1 <= degen_w;
	end

	// s2: dividend |num| * 2^F + |den| (round to nearest), divisor 2 |den|
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			x_s2[k] <= (XE'(nm_s1[k]) << F) + XE'(dm_s1);
		end
		y_s2     <= {dm_s1, 1'b0};
		qneg_s2  <= qneg_s1;
		p_s2     <= p_s1;
		degen_s2 <= degen_s1;
	end

	// one divider per coordinate
	for (genvar k = 0; k < 3; k++) begin : g_div
		tcc_div #(
			.HW (HW),
			.YW (YW),
			.NQ (QB)
		) u_div (
			.clk (clk),
			.hi  (x_s2[k][XE-1:QB]),
			.lo  (x_s2[k][QB-1:0]),
			.y   (y_s2),
			.q   (q_w[k]),
			.ovf (ovf_w[k])
		);
	end

	// side data delayed to match the dividers
	always_ff @(posedge clk) begin
		sd_q[0] <= {degen_s2, qneg_s2, p_s2};
		for (int i = 1; i <= QB; i++) begin
			sd_q[i] <= sd_q[i-1];
		end
	end

	assign {degen_d, qneg_d, p_d} = sd_q[QB];

	// s3: p * 2^F plus or minus the quotient
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (qneg_d[k]) begin
				tot_s3[k] <= (TW'(signed'(p_d[k])) <<< F) - signed'(TW'(q_w[k]));
			end else begin
				tot_s3[k] <= (TW'(signed'(p_d[k])) <<< F) + signed'(TW'(q_w[k]));
			end
			ovf_s3[k] <= ovf_w[k];
		end
		qneg_s3  <= qneg_d;
		degen_s3 <= degen_d;
	end

	// clip to the output range
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (ovf_s3[k]) begin
				c_c[k]   = qneg_s3[k] ? OUT_W'(OMIN) : OUT_W'(OMAX);
				sat_c[k] = 1'b1;
			end else if (tot_s3[k] > OMAX) begin
				c_c[k]   = OUT_W'(OMAX);
				sat_c[k] = 1'b1;
			end else if (tot_s3[k] < OMIN) begin
				c_c[k]   = OUT_W'(OMIN);
				sat_c[k] = 1'b1;
			end else begin
				c_c[k]   = OUT_W'(tot_s3[k]);
				sat_c[k] = 1'b0;
			end
		end
	end

	// result word; degenerate items read as all zero
	always_ff @(posedge clk) begin
		valid_res <= !degen_s3;
		center_x  <= degen_s3 ? '0 : c_c[0];
		center_y  <= degen_s3 ? '0 : c_c[1];
		center_z  <= degen_s3 ? '0 : c_c[2];
		saturated <= !degen_s3 && (|sat_c);
	end

endmodule

// ===== rtl/core/tetra_circumcenter.sv =====
// Top level of the tetrahedron circumcenter block.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------------
//  input     | start / busy          | p_x p_y p_z q_x q_y q_z r_x r_y r_z s_x s_y s_z
//  result    | done (one-cycle)      | valid_res center_x center_y center_z saturated
//  config    | cfg_we                | cfg_wdata (degenerate threshold)
//
// One word accepted per cycle while busy is low; each result appears after its word passes
// the 5 determinant stages, queue, 2 setup stages, 50-stage divider, sum and clip.
// The divider is one quotient bit per stage, so its depth sets the latency.
// Reset clears the threshold to zero and empties every valid chain.
// The receiver cannot stall: results leave on done without backpressure;
// busy rises only if the front/back queue fills.
`timescale 1ns / 1ps
module tetra_circumcenter import tcc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_BITS-1:0]  p_x,
	input  logic signed [COORD_BITS-1:0]  p_y,
	input  logic signed [COORD_BITS-1:0]  p_z,
	input  logic signed [COORD_BITS-1:0]  q_x,
	input  logic signed [COORD_BITS-1:0]  q_y,
	input  logic signed [COORD_BITS-1:0]  q_z,
	input  logic signed [COORD_BITS-1:0]  r_x,
	input  logic signed [COORD_BITS-1:0]  r_y,
	input  logic signed [COORD_BITS-1:0]  r_z,
	input  logic signed [COORD_BITS-1:0]  s_x,
	input  logic signed [COORD_BITS-1:0]  s_y,
	input  logic signed [COORD_BITS-1:0]  s_z,
	input  logic                          cfg_we,
	input  logic [THR_W-1:0]              cfg_wdata,
	output logic                          done,
	output logic                          valid_res,
	output logic signed [OUT_W-1:0]       center_x,
	output logic signed [OUT_W-1:0]       center_y,
	output logic signed [OUT_W-1:0]       center_z,
	output logic                          saturated
);

	localparam int PLW = plw_f(COORD_BITS);

	logic [THR_W-1:0]            thr_q;
	logic [11:0][COORD_BITS-1:0] crd;
	logic                        f_vld;
	logic [PLW-1:0]              f_word;
	logic [PLW-1:0]              b_word;
	q_stat_t                     qs;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	assign crd  = {s_z, s_y, s_x, r_z, r_y, r_x, q_z, q_y, q_x, p_z, p_y, p_x};
	assign busy = qs.full;

	tcc_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (!qs.full),
		.in_vld   (start && !busy),
		.crd      (crd),
		.thr      (thr_q),
		.out_vld  (f_vld),
		.out_word (f_word)
	);

	tcc_fifo #(
		.W     (PLW),
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_vld),
		.din    (f_word),
		.pop    (!qs.empty),
		.dout   (b_word),
		.stat   (qs)
	);

	tcc_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (!qs.empty),
		.in_word   (b_word),
		.done      (done),
		.valid_res (valid_res),
		.center_x  (center_x),
		.center_y  (center_y),
		.center_z  (center_z),
		.saturated (saturated)
	);

endmodule

// ===== rtl/core/tcc_checker.sv =====
// Port-level checks for the tetrahedron circumcenter block, bound to the top level.
`timescale 1ns / 1ps
module tcc_checker import tcc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic                    valid_res,
	input logic signed [OUT_W-1:0] center_x,
	input logic signed [OUT_W-1:0] center_y,
	input logic signed [OUT_W-1:0] center_z,
	input logic                    saturated
);

	localparam logic [OUT_W-1:0] OMAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] OMIN = {1'b1, {(OUT_W-1){1'b0}}};

	// every result comes from an accepted word; the check looks back by LATENCY
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching accepted word");

	// degenerate results carry an all-zero center and no clip flag
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !valid_res |-> center_x == '0 && center_y == '0 && center_z == '0
			&& !saturated)
		else $error("degenerate result not zero");

	// a clip flag means at least one coordinate sits at a range limit
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |-> valid_res && (
			center_x == OMAX || center_x == OMIN ||
			center_y == OMAX || center_y == OMIN ||
			center_z == OMAX || center_z == OMIN))
		else $error("saturated flag without a clipped coordinate");

endmodule

bind tetra_circumcenter tcc_checker u_tcc_checker (.*);
